// ===== hw/rtl/wlrs_pkg.sv =====
package wlrs_pkg;

  localparam int SLOT_COUNT = 2048;
  localparam int SLOT_W = $clog2(SLOT_COUNT);
  localparam int FLASH_DEPTH = SLOT_COUNT * 16;
  localparam int ADDR_W = $clog2(FLASH_DEPTH);
  localparam int DATA_WORDS = 10;

  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_SAVE = 2'd1;
  localparam logic [1:0] ACT_RAW  = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ERASED = 2'd1;
  localparam logic [1:0] ST_BAD    = 2'd2;

  localparam logic [2:0] CFG_MAGIC   = 3'd0;
  localparam logic [2:0] CFG_VERSION = 3'd1;
  localparam logic [2:0] CFG_DEF_X   = 3'd2;
  localparam logic [2:0] CFG_DEF_Y   = 3'd3;
  localparam logic [2:0] CFG_DEF_H   = 3'd4;

  localparam logic [31:0] ERASED_WORD = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  word_index;
    logic [31:0] data_word;
    logic [10:0] slot_index;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  field_index;
    logic [31:0] field_value;
    logic [1:0]  status;
    logic [10:0] slot_used;
    logic        record_valid;
    logic        sector_erased;
    logic        run_end;
  } out_item_t;

  // One 32-bit word folded into the reflected CRC, a bit at a time.
  function automatic logic [31:0] crc_word(input logic [31:0] c_in, input logic [31:0] w);
    logic [31:0] c;
    c = c_in ^ w;
    for (int b = 0; b < 32; b++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/wlrs_if.sv =====
interface wlrs_in_if;
  import wlrs_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t payload;
  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

interface wlrs_out_if;
  import wlrs_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t payload;
  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

interface wlrs_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/wear_levelled_record_store.sv =====
// Load: accept, then a scan of the whole sector at one flash word per cycle, then ten result
// items, each with its word read and then presented.
// Save with last: a scan of the first word of each slot, an erase sweep of the whole flash if
// full, 16 word programs (each a read, then a write), then the result item.
// Raw program: a read, then a write. Staging and ignored items stay in idle. One item at a time.
// Reset: a sweep writes every flash word to all ones; no item is taken meanwhile.
module wear_levelled_record_store (
  input logic clk,
  input logic rst_n,
  wlrs_in_if.sink    in_ch,
  wlrs_out_if.source out_ch,
  wlrs_cfg_if.sink   cfg_ch
);
  import wlrs_pkg::*;

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_LSCAN  = 4'd2;
  localparam logic [3:0] S_LOUT   = 4'd3;
  localparam logic [3:0] S_FREE   = 4'd4;
  localparam logic [3:0] S_ERASE  = 4'd5;
  localparam logic [3:0] S_PRD    = 4'd6;
  localparam logic [3:0] S_PWR    = 4'd7;
  localparam logic [3:0] S_SDONE  = 4'd8;
  localparam logic [3:0] S_RAWRD  = 4'd9;
  localparam logic [3:0] S_RAWWR  = 4'd10;
  localparam logic [3:0] S_LRD    = 4'd11;

  logic [3:0] state_r, state_nxt;
  logic [ADDR_W:0] cnt_r, cnt_nxt;
  logic rd_pend_r, rd_pend_nxt;
  logic [ADDR_W-1:0] rd_addr_r, rd_addr_nxt;
  logic [31:0] crc_r, crc_nxt, w0_r, w0_nxt;
  logic found_r, found_nxt, erased_r, erased_nxt, s0e_r, s0e_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [3:0] oi_r, oi_nxt;
  logic [31:0] rec_r [16];
  logic [31:0] rec_nxt [16];
  logic [31:0] staged_r [DATA_WORDS];
  logic [31:0] magic_r, ver_r, defx_r, defy_r, defh_r;
  logic [ADDR_W-1:0] raw_addr_r, raw_addr_nxt;
  logic [31:0] raw_data_r, raw_data_nxt;
  logic ov_r, ov_nxt;
  out_item_t op_r, op_nxt;

  logic we;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [31:0] wdata, rdata;

  wlrs_flash u_flash (.clk, .we, .waddr, .wdata, .raddr, .rdata);

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready = (state_r == S_IDLE) && !ov_r;
  assign out_ch.valid = ov_r;
  assign out_ch.payload = op_r;

  logic acc;
  in_item_t it;
  assign acc = in_ch.valid && in_ch.ready;
  assign it = in_ch.payload;

  logic [3:0] rd_word;
  logic [SLOT_W-1:0] rd_slot;
  assign rd_word = rd_addr_r[3:0];
  assign rd_slot = rd_addr_r[ADDR_W-1:4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r <= '0; ver_r <= '0; defx_r <= '0; defy_r <= '0; defh_r <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_MAGIC:   magic_r <= cfg_ch.data;
        CFG_VERSION: ver_r <= cfg_ch.data;
        CFG_DEF_X:   defx_r <= cfg_ch.data;
        CFG_DEF_Y:   defy_r <= cfg_ch.data;
        CFG_DEF_H:   defh_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (acc && it.action == ACT_SAVE && it.word_index < 4'(DATA_WORDS)) begin
      staged_r[it.word_index] <= it.data_word;
    end
  end

  always_comb begin
    logic [31:0] cw;
    state_nxt = state_r; cnt_nxt = cnt_r; rd_pend_nxt = 1'b0; rd_addr_nxt = rd_addr_r;
    crc_nxt = crc_r; w0_nxt = w0_r; found_nxt = found_r; erased_nxt = erased_r;
    s0e_nxt = s0e_r; slot_nxt = slot_r; oi_nxt = oi_r; rec_nxt = rec_r;
    raw_addr_nxt = raw_addr_r; raw_data_nxt = raw_data_r;
    ov_nxt = ov_r; op_nxt = op_r;
    we = 1'b0; waddr = cnt_r[ADDR_W-1:0]; wdata = ERASED_WORD; raddr = rd_addr_r;
    cw = 32'd0;
    if (ov_r && out_ch.ready) ov_nxt = 1'b0;
    case (state_r)
      S_CLEAR: begin
        we = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == (ADDR_W+1)'(FLASH_DEPTH - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (acc) begin
          case (it.action)
            ACT_LOAD: begin
              found_nxt = 1'b0; rd_addr_nxt = '0; raddr = '0; rd_pend_nxt = 1'b1;
              crc_nxt = ERASED_WORD; cnt_nxt = '0; state_nxt = S_LSCAN;
            end
            ACT_SAVE: begin
              if (it.last) begin
                rd_addr_nxt = '0; raddr = '0; rd_pend_nxt = 1'b1; erased_nxt = 1'b0;
                state_nxt = S_FREE;
              end
            end
            ACT_RAW: begin
              if ({1'b0, it.slot_index} < 12'(SLOT_COUNT)) begin
                raw_addr_nxt = {SLOT_W'(it.slot_index), it.word_index};
                raw_data_nxt = it.data_word;
                raddr = {SLOT_W'(it.slot_index), it.word_index};
                state_nxt = S_RAWRD;
              end
            end
            default: ;
          endcase
        end
      end
      S_RAWRD: begin
        // Keep the read address so the word is still on rdata when it is written back.
        raddr = raw_addr_r;
        state_nxt = S_RAWWR;
      end
      S_RAWWR: begin
        we = 1'b1; waddr = raw_addr_r; wdata = rdata & raw_data_r; state_nxt = S_IDLE;
      end
      S_LSCAN: begin
        // Reads are issued back to back; rdata belongs to rd_addr_r.
        raddr = rd_addr_r + 1'b1;
        rd_addr_nxt = rd_addr_r + 1'b1;
        if (rd_word == 4'd0) begin
          w0_nxt = rdata;
          crc_nxt = crc_word(ERASED_WORD, rdata);
          if (rd_slot == '0) s0e_nxt = (rdata == ERASED_WORD);
        end else if (rd_word != 4'd15) begin
          crc_nxt = crc_word(crc_r, rdata);
        end else begin
          if (w0_r == magic_r && ~crc_r == rdata) begin
            found_nxt = 1'b1; slot_nxt = rd_slot;
          end
          if (rd_slot == SLOT_W'(SLOT_COUNT - 1)) begin
            oi_nxt = '0; state_nxt = S_LRD;
          end
        end
      end
      S_LRD: begin
        // Read the data word for the next result.
        raddr = {slot_r, oi_r + 4'd2};
        state_nxt = S_LOUT;
      end
      S_LOUT: begin
        // Hold the read address so the word survives a stalled output.
        raddr = {slot_r, oi_r + 4'd2};
        if (!ov_nxt) begin
          ov_nxt = 1'b1;
          op_nxt.field_index = oi_r;
          op_nxt.sector_erased = 1'b0;
          op_nxt.run_end = (oi_r == 4'(DATA_WORDS - 1));
          if (found_r) begin
            op_nxt.field_value = rdata; op_nxt.status = ST_OK;
            op_nxt.slot_used = 11'(slot_r); op_nxt.record_valid = 1'b1;
          end else begin
            case (oi_r)
              4'd0: op_nxt.field_value = defx_r;
              4'd1: op_nxt.field_value = defy_r;
              4'd2: op_nxt.field_value = defh_r;
              default: op_nxt.field_value = 32'd0;
            endcase
            op_nxt.status = s0e_r ? ST_ERASED : ST_BAD;
            op_nxt.slot_used = '0; op_nxt.record_valid = 1'b0;
          end
          oi_nxt = oi_r + 1'b1;
          state_nxt = (oi_r == 4'(DATA_WORDS - 1)) ? S_IDLE : S_LRD;
        end
      end
      S_FREE: begin
        // rd_pend_r marks the cycle a first-word read is in flight.
        if (!rd_pend_r) begin
          raddr = rd_addr_r; rd_pend_nxt = 1'b1;
        end else if (rdata == ERASED_WORD) begin
          slot_nxt = rd_slot; state_nxt = S_PRD; cnt_nxt = '0;
        end else if (rd_slot == SLOT_W'(SLOT_COUNT - 1)) begin
          erased_nxt = 1'b1; slot_nxt = '0; cnt_nxt = '0; state_nxt = S_ERASE;
        end else begin
          rd_addr_nxt = {rd_slot + 1'b1, 4'd0};
        end
        if (state_nxt != S_FREE || !rd_pend_r) begin
          rec_nxt[0] = magic_r; rec_nxt[1] = ver_r;
          for (int i = 0; i < DATA_WORDS; i++) rec_nxt[2+i] = staged_r[i];
          rec_nxt[12] = '0; rec_nxt[13] = '0; rec_nxt[14] = '0;
          cw = ERASED_WORD;
          for (int i = 0; i < 2; i++) cw = crc_word(cw, rec_nxt[i]);
          crc_nxt = cw;
        end
      end
      S_ERASE: begin
        we = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == (ADDR_W+1)'(FLASH_DEPTH - 1)) begin
          cnt_nxt = '0; state_nxt = S_PRD;
        end
      end
      S_PRD: begin
        // CRC advances one record word per programmed word, for words 2 to 14.
        raddr = {slot_r, cnt_r[3:0]};
        if (cnt_r[3:0] >= 4'd2 && cnt_r[3:0] <= 4'd14)
          crc_nxt = crc_word(crc_r, rec_r[cnt_r[3:0]]);
        state_nxt = S_PWR;
      end
      S_PWR: begin
        we = 1'b1; waddr = {slot_r, cnt_r[3:0]};
        wdata = rdata & ((cnt_r[3:0] == 4'd15) ? ~crc_r : rec_r[cnt_r[3:0]]);
        cnt_nxt = cnt_r + 1'b1;
        state_nxt = (cnt_r[3:0] == 4'd15) ? S_SDONE : S_PRD;
      end
      S_SDONE: begin
        if (!ov_nxt) begin
          ov_nxt = 1'b1;
          op_nxt.field_index = '0; op_nxt.field_value = '0; op_nxt.status = ST_OK;
          op_nxt.slot_used = 11'(slot_r); op_nxt.record_valid = 1'b1;
          op_nxt.sector_erased = erased_r; op_nxt.run_end = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR; cnt_r <= '0; ov_r <= 1'b0; rd_pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; ov_r <= ov_nxt; rd_pend_r <= rd_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r <= rd_addr_nxt; crc_r <= crc_nxt; w0_r <= w0_nxt; found_r <= found_nxt;
    erased_r <= erased_nxt; s0e_r <= s0e_nxt; slot_r <= slot_nxt; oi_r <= oi_nxt;
    rec_r <= rec_nxt; raw_addr_r <= raw_addr_nxt; raw_data_r <= raw_data_nxt;
    op_r <= op_nxt;
  end
endmodule

// ===== hw/rtl/wlrs_flash.sv =====
module wlrs_flash (
  input  logic                      clk,
  input  logic                      we,
  input  logic [wlrs_pkg::ADDR_W-1:0] waddr,
  input  logic [31:0]               wdata,
  input  logic [wlrs_pkg::ADDR_W-1:0] raddr,
  output logic [31:0]               rdata
);
  import wlrs_pkg::*;

  logic [31:0] mem [FLASH_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
